### rtl/sar_pkg.sv
// Shared types and constants for the sensor axis rotation block.
// Holds orientation codes, per-axis result kinds and Q1.15 coefficients.
// No dependencies.
package sar_pkg;

  localparam int CODE_W = 6;

  // Q1.15 fixed point
  localparam int COEF_FRAC  = 15;
  localparam int ROUND_HALF = 1 << (COEF_FRAC - 1);
  localparam int HALF_SQRT2 = 23170;
  localparam int COEF_W     = 16;

  // Fixed mounting matrix, row-major: x row, y row, z row
  localparam int MAT_COEF [9] = '{
      4687,  12084, -30096,
    -10883, -28059, -12961,
    -30550,  11850,      0
  };

  // Orientation codes
  localparam logic [CODE_W-1:0] ORIENT_NONE              = 6'd0;
  localparam logic [CODE_W-1:0] ORIENT_YAW_45            = 6'd1;
  localparam logic [CODE_W-1:0] ORIENT_YAW_90            = 6'd2;
  localparam logic [CODE_W-1:0] ORIENT_YAW_135           = 6'd3;
  localparam logic [CODE_W-1:0] ORIENT_YAW_180           = 6'd4;
  localparam logic [CODE_W-1:0] ORIENT_YAW_225           = 6'd5;
  localparam logic [CODE_W-1:0] ORIENT_YAW_270           = 6'd6;
  localparam logic [CODE_W-1:0] ORIENT_YAW_315           = 6'd7;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180          = 6'd8;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_45   = 6'd9;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_90   = 6'd10;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_135  = 6'd11;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_180         = 6'd12;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_225  = 6'd13;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_270  = 6'd14;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_YAW_315  = 6'd15;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_90           = 6'd16;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_90_YAW_45    = 6'd17;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_90_YAW_90    = 6'd18;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_90_YAW_135   = 6'd19;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_270          = 6'd20;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_270_YAW_45   = 6'd21;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_270_YAW_90   = 6'd22;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_270_YAW_135  = 6'd23;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_270_YAW_270  = 6'd24;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_90          = 6'd25;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_270         = 6'd26;
  localparam logic [CODE_W-1:0] ORIENT_ROLL_180_PITCH_270 = 6'd27;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_90_YAW_180  = 6'd28;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_90_ROLL_90  = 6'd29;
  localparam logic [CODE_W-1:0] ORIENT_MATRIX            = 6'd30;
  localparam logic [CODE_W-1:0] ORIENT_PITCH_90_ROLL_270 = 6'd31;
  localparam logic [CODE_W-1:0] ORIENT_ACC_DOWN          = 6'd32;
  localparam logic [CODE_W-1:0] ORIENT_GYRO_DOWN         = 6'd33;
  localparam logic [CODE_W-1:0] ORIENT_ACC_UP            = 6'd34;
  localparam logic [CODE_W-1:0] ORIENT_GYRO_UP           = 6'd35;

  // How each result axis is formed
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_HALF,
    KIND_MATRIX
  } axis_kind_e;

  typedef struct packed {
    axis_kind_e x;
    axis_kind_e y;
    axis_kind_e z;
  } route_t;

endpackage

### rtl/sar_route.sv
// Orientation decode: picks, per result axis, a swapped/negated input axis,
// the operand of the sqrt(2)/2 scaling or the fixed matrix. Depends on sar_pkg.
module sar_route
  import sar_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic [CODE_W-1:0]              code_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] z_i,
  output route_t                         route_o,
  output logic signed [SAMPLE_WIDTH:0]   dir_x_o,
  output logic signed [SAMPLE_WIDTH:0]   dir_y_o,
  output logic signed [SAMPLE_WIDTH:0]   dir_z_o,
  output logic signed [SAMPLE_WIDTH+1:0] half_x_o,
  output logic signed [SAMPLE_WIDTH+1:0] half_y_o
);

  localparam int OpW = SAMPLE_WIDTH + 2;

  logic signed [OpW-1:0] ex, ey, ez;
  logic signed [OpW-1:0] nx, ny, nz;
  logic signed [OpW-1:0] dx, dy, dz;
  logic signed [OpW-1:0] hx, hy;

  assign ex = {{2{x_i[SAMPLE_WIDTH-1]}}, x_i};
  assign ey = {{2{y_i[SAMPLE_WIDTH-1]}}, y_i};
  assign ez = {{2{z_i[SAMPLE_WIDTH-1]}}, z_i};
  assign nx = -ex;
  assign ny = -ey;
  assign nz = -ez;

  always_comb begin
    route_o = '{x: KIND_DIRECT, y: KIND_DIRECT, z: KIND_DIRECT};
    dx = ex;
    dy = ey;
    dz = ez;
    hx = '0;
    hy = '0;
    case (code_i)
      ORIENT_YAW_45: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex - ey; hy = ex + ey;
      end
      ORIENT_YAW_90: begin
        dx = ny; dy = ex;
      end
      ORIENT_YAW_135: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = nx - ey; hy = ex - ey;
      end
      ORIENT_YAW_180: begin
        dx = nx; dy = ny;
      end
      ORIENT_YAW_225: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ey - ex; hy = nx - ey;
      end
      ORIENT_YAW_270: begin
        dx = ey; dy = nx;
      end
      ORIENT_YAW_315: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex + ey; hy = ey - ex;
      end
      ORIENT_ROLL_180: begin
        dy = ny; dz = nz;
      end
      ORIENT_ROLL_180_YAW_45: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex + ey; hy = ex - ey; dz = nz;
      end
      ORIENT_ROLL_180_YAW_90: begin
        dx = ey; dy = ex; dz = nz;
      end
      ORIENT_ROLL_180_YAW_135: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ey - ex; hy = ey + ex; dz = nz;
      end
      ORIENT_PITCH_180: begin
        dx = nx; dz = nz;
      end
      ORIENT_ROLL_180_YAW_225: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = nx - ey; hy = ey - ex; dz = nz;
      end
      ORIENT_ROLL_180_YAW_270: begin
        dx = ny; dy = nx; dz = nz;
      end
      ORIENT_ROLL_180_YAW_315: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex - ey; hy = nx - ey; dz = nz;
      end
      ORIENT_ROLL_90: begin
        dy = nz; dz = ey;
      end
      ORIENT_ROLL_90_YAW_45: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex + ez; hy = ex - ez; dz = ey;
      end
      ORIENT_ROLL_90_YAW_90: begin
        dx = ez; dy = ex; dz = ey;
      end
      ORIENT_ROLL_90_YAW_135: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ez - ex; hy = ex + ez; dz = ey;
      end
      ORIENT_ROLL_270: begin
        dy = ez; dz = ny;
      end
      ORIENT_ROLL_270_YAW_45: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = ex - ez; hy = ex + ez; dz = ny;
      end
      ORIENT_ROLL_270_YAW_90: begin
        dx = nz; dy = ex; dz = ny;
      end
      ORIENT_ROLL_270_YAW_135: begin
        route_o.x = KIND_HALF; route_o.y = KIND_HALF;
        hx = nx - ez; hy = ex - ez; dz = ny;
      end
      ORIENT_ROLL_270_YAW_270: begin
        dx = ez; dy = nx; dz = ny;
      end
      ORIENT_PITCH_90: begin
        dx = ez; dz = nx;
      end
      ORIENT_PITCH_270: begin
        dx = nz; dz = ex;
      end
      ORIENT_ROLL_180_PITCH_270, ORIENT_PITCH_90_YAW_180: begin
        dx = ez; dy = ny; dz = ex;
      end
      ORIENT_PITCH_90_ROLL_90: begin
        dx = ey; dy = nz; dz = nx;
      end
      ORIENT_MATRIX: begin
        route_o = '{x: KIND_MATRIX, y: KIND_MATRIX, z: KIND_MATRIX};
      end
      ORIENT_PITCH_90_ROLL_270: begin
        dx = ny; dy = ez; dz = nx;
      end
      ORIENT_ACC_DOWN: begin
        dx = ny; dy = nx;
      end
      ORIENT_GYRO_DOWN: begin
        dx = ey; dy = ex; dz = nz;
      end
      ORIENT_ACC_UP: begin
        dx = ny; dy = ex; dz = nz;
      end
      ORIENT_GYRO_UP: begin
        dx = ey; dy = nx;
      end
      default: begin
        // no rotation, and pass through for unlisted codes
        dx = ex;
      end
    endcase
  end

  // every direct value fits one bit over the sample width
  assign dir_x_o  = dx[SAMPLE_WIDTH:0];
  assign dir_y_o  = dy[SAMPLE_WIDTH:0];
  assign dir_z_o  = dz[SAMPLE_WIDTH:0];
  assign half_x_o = hx;
  assign half_y_o = hy;

endmodule

### rtl/sar_product.sv
// Product stage: constant multiplies for the 45-degree scaling and the fixed
// matrix, registered with the routed values. Depends on sar_pkg.
module sar_product
  import sar_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  route_t                            route_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    z_i,
  input  logic signed [SAMPLE_WIDTH:0]      dir_x_i,
  input  logic signed [SAMPLE_WIDTH:0]      dir_y_i,
  input  logic signed [SAMPLE_WIDTH:0]      dir_z_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    half_x_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    half_y_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output route_t                            route_o,
  output logic signed [SAMPLE_WIDTH:0]      dir_x_o,
  output logic signed [SAMPLE_WIDTH:0]      dir_y_o,
  output logic signed [SAMPLE_WIDTH:0]      dir_z_o,
  output logic signed [SAMPLE_WIDTH+17:0]   half_x_o,
  output logic signed [SAMPLE_WIDTH+17:0]   half_y_o,
  output logic signed [SAMPLE_WIDTH+15:0]   term_o [9]
);

  localparam int PW = SAMPLE_WIDTH + 18;
  localparam int MW = SAMPLE_WIDTH + COEF_W;
  localparam logic signed [PW-1:0] HalfCoef = PW'(HALF_SQRT2);

  logic                  valid_q;
  logic                  load;
  logic signed [PW-1:0]  half_x_d, half_y_d;
  logic signed [MW-1:0]  axis_ext [3];
  logic signed [MW-1:0]  term_d [9];
  logic signed [MW-1:0]  term_q [9];
  route_t                route_q;
  logic signed [SAMPLE_WIDTH:0] dir_x_q, dir_y_q, dir_z_q;
  logic signed [PW-1:0]  half_x_q, half_y_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign half_x_d = $signed({{16{half_x_i[SAMPLE_WIDTH+1]}}, half_x_i}) * HalfCoef;
  assign half_y_d = $signed({{16{half_y_i[SAMPLE_WIDTH+1]}}, half_y_i}) * HalfCoef;

  assign axis_ext[0] = {{COEF_W{x_i[SAMPLE_WIDTH-1]}}, x_i};
  assign axis_ext[1] = {{COEF_W{y_i[SAMPLE_WIDTH-1]}}, y_i};
  assign axis_ext[2] = {{COEF_W{z_i[SAMPLE_WIDTH-1]}}, z_i};

  for (genvar t = 0; t < 9; t++) begin : g_term
    localparam logic signed [MW-1:0] Coef = MW'(MAT_COEF[t]);
    assign term_d[t] = axis_ext[t % 3] * Coef;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      route_q  <= route_i;
      dir_x_q  <= dir_x_i;
      dir_y_q  <= dir_y_i;
      dir_z_q  <= dir_z_i;
      half_x_q <= half_x_d;
      half_y_q <= half_y_d;
      term_q   <= term_d;
    end
  end

  assign valid_o  = valid_q;
  assign route_o  = route_q;
  assign dir_x_o  = dir_x_q;
  assign dir_y_o  = dir_y_q;
  assign dir_z_o  = dir_z_q;
  assign half_x_o = half_x_q;
  assign half_y_o = half_y_q;
  assign term_o   = term_q;

endmodule

### rtl/sar_combine.sv
// Result stage: sums matrix terms, rounds Q1.15 products to nearest and
// selects each axis into the output register. Depends on sar_pkg.
module sar_combine
  import sar_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  route_t                           route_i,
  input  logic signed [SAMPLE_WIDTH:0]     dir_x_i,
  input  logic signed [SAMPLE_WIDTH:0]     dir_y_i,
  input  logic signed [SAMPLE_WIDTH:0]     dir_z_i,
  input  logic signed [SAMPLE_WIDTH+17:0]  half_x_i,
  input  logic signed [SAMPLE_WIDTH+17:0]  half_y_i,
  input  logic signed [SAMPLE_WIDTH+15:0]  term_i [9],
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [SAMPLE_WIDTH:0]     board_x_o,
  output logic signed [SAMPLE_WIDTH:0]     board_y_o,
  output logic signed [SAMPLE_WIDTH:0]     board_z_o
);

  localparam int PW = SAMPLE_WIDTH + 18;
  localparam int OW = SAMPLE_WIDTH + 1;
  localparam logic signed [PW-1:0] Bias = PW'(ROUND_HALF);

  logic                  valid_q;
  logic                  load;
  logic signed [PW-1:0]  row_sum [3];
  logic signed [PW-1:0]  row_rnd [3];
  logic signed [PW-1:0]  half_x_rnd, half_y_rnd;
  logic signed [OW-1:0]  board_x_d, board_y_d, board_z_d;
  logic signed [OW-1:0]  board_x_q, board_y_q, board_z_q;

  for (genvar r = 0; r < 3; r++) begin : g_row
    assign row_sum[r] = {{2{term_i[3*r][PW-3]}}, term_i[3*r]}
                      + {{2{term_i[3*r+1][PW-3]}}, term_i[3*r+1]}
                      + {{2{term_i[3*r+2][PW-3]}}, term_i[3*r+2]};
    assign row_rnd[r] = row_sum[r] + Bias;
  end

  assign half_x_rnd = half_x_i + Bias;
  assign half_y_rnd = half_y_i + Bias;

  // floor((p + 2^14) / 2^15), kept to the output width
  always_comb begin
    case (route_i.x)
      KIND_HALF:   board_x_d = half_x_rnd[COEF_FRAC+OW-1:COEF_FRAC];
      KIND_MATRIX: board_x_d = row_rnd[0][COEF_FRAC+OW-1:COEF_FRAC];
      default:     board_x_d = dir_x_i;
    endcase
    case (route_i.y)
      KIND_HALF:   board_y_d = half_y_rnd[COEF_FRAC+OW-1:COEF_FRAC];
      KIND_MATRIX: board_y_d = row_rnd[1][COEF_FRAC+OW-1:COEF_FRAC];
      default:     board_y_d = dir_y_i;
    endcase
    case (route_i.z)
      KIND_MATRIX: board_z_d = row_rnd[2][COEF_FRAC+OW-1:COEF_FRAC];
      default:     board_z_d = dir_z_i;
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      board_x_q <= board_x_d;
      board_y_q <= board_y_d;
      board_z_q <= board_z_d;
    end
  end

  assign valid_o   = valid_q;
  assign board_x_o = board_x_q;
  assign board_y_o = board_y_q;
  assign board_z_o = board_z_q;

endmodule

### rtl/sensor_axis_rotation.sv
// Top level of the sensor axis rotation block: input register, orientation
// decode, product stage and result stage. Depends on sar_pkg, sar_route,
// sar_product and sar_combine.
//
// Usage: write the 6-bit orientation code on cfg_wdata_i with cfg_we_i high
// while the block is idle; it resets to 0 (no rotation). Codes above 35
// pass samples through. Feed samples on the s_axis channel; rotated samples
// leave on the m_axis channel, one result per sample, in order.
// A sample accepted into the input register passes the product register and
// then the result register before it is shown on m_axis.
// Throughput: one sample per cycle while m_axis_tready is high; each register
// stage holds one item and advances whenever the stage after it is empty or being drained.
// Stall: when m_axis_tready is low, results hold in the result register and
// the stages behind fill up; s_axis_tready drops only once all three stages
// hold an item.
// Reset (rst_ni low, asynchronous) empties all stages and clears the code.
module sensor_axis_rotation
  import sar_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  localparam int InDataW  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((3 * (SAMPLE_WIDTH + 1) + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CODE_W-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample_x, sample_y, sample_z, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // board_x, board_y, board_z, zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int SW = SAMPLE_WIDTH;

  logic [CODE_W-1:0]     code_q;
  logic                  in_valid_q;
  logic                  in_ready;
  logic                  in_load;
  logic signed [SW-1:0]  x_q, y_q, z_q;

  route_t                route;
  logic signed [SW:0]    dir_x, dir_y, dir_z;
  logic signed [SW+1:0]  half_x, half_y;

  logic                  prod_valid, prod_ready;
  logic                  prod_ready_dn;
  route_t                prod_route;
  logic signed [SW:0]    prod_dir_x, prod_dir_y, prod_dir_z;
  logic signed [SW+17:0] prod_half_x, prod_half_y;
  logic signed [SW+15:0] prod_term [9];

  logic signed [SW:0]    board_x, board_y, board_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= ORIENT_NONE;
    end else if (cfg_we_i) begin
      code_q <= cfg_wdata_i;
    end
  end

  assign in_ready      = !in_valid_q || prod_ready;
  assign in_load       = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      x_q <= s_axis_tdata[SW-1:0];
      y_q <= s_axis_tdata[2*SW-1:SW];
      z_q <= s_axis_tdata[3*SW-1:2*SW];
    end
  end

  sar_route #(
    .SAMPLE_WIDTH(SW)
  ) u_route (
    .code_i  (code_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .route_o (route),
    .dir_x_o (dir_x),
    .dir_y_o (dir_y),
    .dir_z_o (dir_z),
    .half_x_o(half_x),
    .half_y_o(half_y)
  );

  sar_product #(
    .SAMPLE_WIDTH(SW)
  ) u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (prod_ready),
    .route_i (route),
    .x_i     (x_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .dir_x_i (dir_x),
    .dir_y_i (dir_y),
    .dir_z_i (dir_z),
    .half_x_i(half_x),
    .half_y_i(half_y),
    .valid_o (prod_valid),
    .ready_i (prod_ready_dn),
    .route_o (prod_route),
    .dir_x_o (prod_dir_x),
    .dir_y_o (prod_dir_y),
    .dir_z_o (prod_dir_z),
    .half_x_o(prod_half_x),
    .half_y_o(prod_half_y),
    .term_o  (prod_term)
  );

  sar_combine #(
    .SAMPLE_WIDTH(SW)
  ) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (prod_valid),
    .ready_o  (prod_ready_dn),
    .route_i  (prod_route),
    .dir_x_i  (prod_dir_x),
    .dir_y_i  (prod_dir_y),
    .dir_z_i  (prod_dir_z),
    .half_x_i (prod_half_x),
    .half_y_i (prod_half_y),
    .term_i   (prod_term),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .board_x_o(board_x),
    .board_y_o(board_y),
    .board_z_o(board_z)
  );

  assign m_axis_tdata = OutDataW'({board_z, board_y, board_x});

endmodule
